>>> sv/ufe_pkg.sv
// Shared types and constants for the union-find edge filter.
`default_nettype none

package ufe_pkg;

    localparam int NUM_VERTICES = 256;
    localparam int VERTEX_W     = 8;
    localparam int COUNT_W      = 8;

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic
    {
        OP_EDGE  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    // One result word.
    typedef struct packed
    {
        logic    taken;
        vertex_t edge_a;
        vertex_t edge_b;
        count_t  count;
    } result_t;

    // One access request to the parent memory.
    typedef struct packed
    {
        logic    rd_en;
        vertex_t rd_addr;
        logic    wr_en;
        vertex_t wr_addr;
        vertex_t wr_data;
        logic    clr;
    } mem_req_t;

endpackage

`default_nettype wire

>>> sv/ufe_parent_mem.sv
// Parent pointer memory with per-entry valid bits; an unwritten entry reads as its own root.
`default_nettype none

module ufe_parent_mem
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ufe_pkg::mem_req_t req,
    output ufe_pkg::vertex_t      rd_parent
);
    import ufe_pkg::*;

    vertex_t                  parent_mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0]  valid_reg;
    vertex_t                  rd_data_reg;
    vertex_t                  rd_addr_reg;
    logic                     rd_valid_reg;
    logic                     fwd_reg;
    vertex_t                  fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            parent_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg  <= parent_mem[req.rd_addr];
            rd_addr_reg  <= req.rd_addr;
            fwd_data_reg <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
                // same-cycle write to the read entry: forward it
                fwd_reg      <= req.wr_en && (req.wr_addr == req.rd_addr);
            end
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rd_parent = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_parent = rd_data_reg;
        end
        else
        begin
            rd_parent = rd_addr_reg;
        end
    end

    a_no_clr_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        req.clr |-> !req.wr_en && !req.rd_en)
        else $error("parent memory cleared while accessed");

    a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
        req.clr |=> valid_reg == '0)
        else $error("valid bits not cleared");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> valid_reg[$past(req.wr_addr)])
        else $error("written entry not marked valid");

endmodule

`default_nettype wire

>>> sv/ufe_ctrl.sv
// Sequencer: root walks, path compression, union, clear and edge count.
`default_nettype none

module ufe_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             op,
    input  wire ufe_pkg::vertex_t vertex_a,
    input  wire ufe_pkg::vertex_t vertex_b,
    input  wire logic             slot_free,
    input  wire ufe_pkg::vertex_t rd_parent,
    output logic                  idle,
    output logic                  res_valid,
    output ufe_pkg::result_t      res,
    output ufe_pkg::mem_req_t     req
);
    import ufe_pkg::*;

    typedef enum logic [7:0]
    {
        S_IDLE   = 8'b0000_0001,
        S_FIND_A = 8'b0000_0010,
        S_COMP_A = 8'b0000_0100,
        S_FIND_B = 8'b0000_1000,
        S_COMP_B = 8'b0001_0000,
        S_MERGE  = 8'b0010_0000,
        S_DONE   = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

    localparam logic [VERTEX_W:0] VERTEX_LIMIT = (VERTEX_W+1)'(NUM_VERTICES);

    state_t  state_reg, state_next;
    vertex_t a_reg, a_next;
    vertex_t b_reg, b_next;
    vertex_t cur_reg, cur_next;
    vertex_t ra_reg, ra_next;
    vertex_t rb_reg, rb_next;
    logic    taken_reg, taken_next;
    count_t  count_reg, count_next;
    logic    in_range;

    assign in_range = ({1'b0, vertex_a} < VERTEX_LIMIT) && ({1'b0, vertex_b} < VERTEX_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cur_next   = cur_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        taken_next = taken_reg;
        count_next = count_reg;
        req        = '0;
        res_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = vertex_a;
                    b_next     = vertex_b;
                    taken_next = 1'b0;
                    if (op == OP_CLEAR)
                    begin
                        req.clr    = 1'b1;
                        count_next = '0;
                        a_next     = '0;
                        b_next     = '0;
                        state_next = S_DONE;
                    end
                    else if (in_range)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = vertex_a;
                        cur_next    = vertex_a;
                        state_next  = S_FIND_A;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_FIND_A:
            begin
                req.rd_en = 1'b1;
                if (rd_parent == cur_reg)
                begin
                    ra_next = cur_reg;
                    if (a_reg == cur_reg)
                    begin
                        req.rd_addr = b_reg;
                        cur_next    = b_reg;
                        state_next  = S_FIND_B;
                    end
                    else
                    begin
                        req.rd_addr = a_reg;
                        cur_next    = a_reg;
                        state_next  = S_COMP_A;
                    end
                end
                else
                begin
                    req.rd_addr = rd_parent;
                    cur_next    = rd_parent;
                end
            end

            S_COMP_A:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_reg;
                req.wr_data = ra_reg;
                req.rd_en   = 1'b1;
                if (rd_parent == ra_reg)
                begin
                    req.rd_addr = b_reg;
                    cur_next    = b_reg;
                    state_next  = S_FIND_B;
                end
                else
                begin
                    req.rd_addr = rd_parent;
                    cur_next    = rd_parent;
                end
            end

            S_FIND_B:
            begin
                if (rd_parent == cur_reg)
                begin
                    rb_next = cur_reg;
                    if (b_reg == cur_reg)
                    begin
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = b_reg;
                        cur_next    = b_reg;
                        state_next  = S_COMP_B;
                    end
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_parent;
                    cur_next    = rd_parent;
                end
            end

            S_COMP_B:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_reg;
                req.wr_data = rb_reg;
                if (rd_parent == rb_reg)
                begin
                    state_next = S_MERGE;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rd_parent;
                    cur_next    = rd_parent;
                end
            end

            S_MERGE:
            begin
                if (ra_reg != rb_reg)
                begin
                    // larger root hangs under the smaller one
                    req.wr_en = 1'b1;
                    if (ra_reg < rb_reg)
                    begin
                        req.wr_addr = rb_reg;
                        req.wr_data = ra_reg;
                    end
                    else
                    begin
                        req.wr_addr = ra_reg;
                        req.wr_data = rb_reg;
                    end
                    taken_next = 1'b1;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        cur_reg   <= cur_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        taken_reg <= taken_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res.taken  = taken_reg;
    assign res.edge_a = a_reg;
    assign res.edge_b = b_reg;
    assign res.count  = count_reg;

    a_no_self_parent: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> req.wr_data != req.wr_addr)
        else $error("entry written to point at itself");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> slot_free)
        else $error("result emitted into an occupied output slot");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |=> !idle)
        else $error("accepted word did not start the sequencer");

    a_count_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE && count_reg == COUNT_MAX) |=> count_reg == COUNT_MAX)
        else $error("edge count wrapped");

endmodule

`default_nettype wire

>>> sv/kruskal_union_find_edge_filter_core.sv
// Top level of the Kruskal union-find edge filter: input handshake and output register.
//
// Usage: edges arrive on the input channel (in_valid/in_stall) already sorted by
// weight, one word per edge: op, vertex_a, vertex_b. op = edge walks both parent
// chains, compresses them and joins the trees if the roots differ; op = clear makes
// every vertex its own root again and zeroes the count.
// Each input word gives exactly one output word (out_valid/out_stall): taken,
// the echoed endpoints and the running tree edge count (all zero for a clear).
// One item is in the sequencer at a time; in_stall is high while it works, and it
// drops in the same cycle that the result enters the output register.
// A clear goes straight to the result. An edge walks the parent chain of vertex_a to
// its root, points every entry on that chain at the root, does the same for vertex_b
// and then joins the two roots if they differ; each hop is one read of the parent
// memory, which has one read port and one write port. With path compression chains stay short.
// The result waits in an output register: while out_stall holds it, the next
// input word is still accepted and worked on, and only its final result waits.
// Reset (rst_n, asynchronous) empties the output register, zeroes the count and
// clears all valid bits of the parent memory, so every vertex is a root.
`default_nettype none

module kruskal_union_find_edge_filter_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             op,
    input  wire ufe_pkg::vertex_t vertex_a,
    input  wire ufe_pkg::vertex_t vertex_b,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  taken,
    output ufe_pkg::vertex_t      tree_edge_a,
    output ufe_pkg::vertex_t      tree_edge_b,
    output ufe_pkg::count_t       edge_count
);
    import ufe_pkg::*;

    logic     ctrl_idle;
    logic     start;
    logic     slot_free;
    logic     res_valid;
    result_t  res;
    mem_req_t mem_req;
    vertex_t  rd_parent;

    logic     out_valid_reg, out_valid_next;
    result_t  out_word_reg;

    // input side: accept only while the sequencer is idle
    assign in_stall = !ctrl_idle;
    assign start    = in_valid && ctrl_idle;

    // output slot free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_word_reg <= res;
        end
    end

    ufe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .slot_free (slot_free),
        .rd_parent (rd_parent),
        .idle      (ctrl_idle),
        .res_valid (res_valid),
        .res       (res),
        .req       (mem_req)
    );

    ufe_parent_mem u_parent_mem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .rd_parent (rd_parent)
    );

    assign out_valid   = out_valid_reg;
    assign taken       = out_word_reg.taken;
    assign tree_edge_a = out_word_reg.edge_a;
    assign tree_edge_b = out_word_reg.edge_b;
    assign edge_count  = out_word_reg.count;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !res_valid)
        else $error("held output word overwritten");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> in_stall)
        else $error("second word accepted while one is in flight");

    a_clear_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && op == OP_CLEAR) |=> (res_valid || !slot_free) && res.count == '0)
        else $error("clear did not zero the result");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the Kruskal union-find edge filter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufe_pkg::*;

    // Run shape
    localparam int RANDOM_WORDS = 680;   // random part, on top of the directed words
    localparam int CALM_WORDS   = 80;    // tail of the run with no idling on either side
    localparam int PRESSURE_AT  = 120;   // word index at which the long output hold-off starts
    localparam int HOLD_CYCLES  = 120;   // length of that hold-off
    localparam int DRAIN_CYCLES = 40;    // settle time once nothing is expected
    localparam int IDLE_LIMIT   = 4000;  // watchdog: cycles with no word moving on either side

    // One input word as the sender keeps it.
    typedef struct
    {
        op_t     kind;
        vertex_t a;
        vertex_t b;
    } edge_word_t;

    // Shadow forest: predicts every result word and checks the block against it.
    class tree_edge_scoreboard;
        int          forest[NUM_VERTICES];   // <0: root, minus tree size; else parent index
        count_t      tree_edges;
        result_t     pending_tree_words[$];
        int unsigned mismatches;

        function new();
            clear_forest();
            mismatches = 0;
        endfunction

        function void clear_forest();
            foreach (forest[i])
                forest[i] = -1;
            tree_edges = '0;
        endfunction

        // Root lookup; every vertex on the walked path is pointed straight at the root.
        function int unsigned find_root(int unsigned v);
            int unsigned r;
            int unsigned nxt;
            r = v;
            while (forest[r] >= 0)
                r = forest[r];
            while (v != r && forest[v] >= 0)
            begin
                nxt       = forest[v];
                forest[v] = r;
                v         = nxt;
            end
            return r;
        endfunction

        function void note_word(op_t kind, vertex_t a, vertex_t b);
            result_t     w;
            int unsigned ra;
            int unsigned rb;
            int unsigned lo;
            int unsigned hi;
            w = '0;
            if (kind == OP_CLEAR)
            begin
                clear_forest();
            end
            else
            begin
                w.edge_a = a;
                w.edge_b = b;
                if (a < NUM_VERTICES && b < NUM_VERTICES)
                begin
                    ra = find_root(a);
                    rb = find_root(b);
                    if (ra != rb)
                    begin
                        lo = (ra < rb) ? ra : rb;
                        hi = (ra < rb) ? rb : ra;
                        forest[lo] += forest[hi];
                        forest[hi]  = lo;
                        w.taken     = 1'b1;
                        if (tree_edges != COUNT_MAX)
                            tree_edges++;
                    end
                end
                w.count = tree_edges;
            end
            pending_tree_words.push_back(w);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_word(logic taken_q, vertex_t a, vertex_t b, count_t c);
            result_t w;
            if (pending_tree_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word taken=%0b a=%0d b=%0d count=%0d",
                                          taken_q, a, b, c));
                return;
            end
            w = pending_tree_words.pop_front();
            if (taken_q !== w.taken)
                report_mismatch($sformatf("taken %0b, want %0b (edge %0d-%0d)",
                                          taken_q, w.taken, w.edge_a, w.edge_b));
            if (a !== w.edge_a)
                report_mismatch($sformatf("tree_edge_a %0d, want %0d", a, w.edge_a));
            if (b !== w.edge_b)
                report_mismatch($sformatf("tree_edge_b %0d, want %0d", b, w.edge_b));
            if (c !== w.count)
                report_mismatch($sformatf("edge_count %0d, want %0d (edge %0d-%0d)",
                                          c, w.count, w.edge_a, w.edge_b));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    logic    op;
    vertex_t vertex_a;
    vertex_t vertex_b;
    logic    out_valid;
    logic    out_stall;
    logic    taken;
    vertex_t tree_edge_a;
    vertex_t tree_edge_b;
    count_t  edge_count;

    tree_edge_scoreboard sb;
    edge_word_t          edge_words[$];
    bit                  calm_tail;      // no idling once set
    bit                  hold_request;   // sender asks the receiver for the long hold-off
    int unsigned         idle_cycles;

    kruskal_union_find_edge_filter_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .taken       (taken),
        .tree_edge_a (tree_edge_a),
        .tree_edge_b (tree_edge_b),
        .edge_count  (edge_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task add_word(op_t kind, vertex_t a, vertex_t b);
        edge_word_t w;
        w.kind = kind;
        w.a    = a;
        w.b    = b;
        edge_words.push_back(w);
    endtask

    // Directed opening, then mostly small graphs (clear + edges over a narrow vertex
    // window so trees merge and many edges fall inside one tree), some noise words,
    // and one large graph over the whole vertex range to push the count up.
    task build_stimulus();
        int  k;
        int  base;
        int  span;
        int  total;
        bit  big_done;
        big_done = 1'b0;

        // Directed part
        add_word(OP_CLEAR, 8'hFF, 8'hFF);          // clear with junk endpoints
        add_word(OP_EDGE, 8'd0, 8'd255);           // extremes, taken
        add_word(OP_EDGE, 8'd255, 8'd0);           // same tree now: not taken
        add_word(OP_EDGE, 8'd7, 8'd7);             // self loop
        add_word(OP_EDGE, 8'd255, 8'd255);         // self loop at the top vertex
        // Descending unions build a deep chain 210 -> 209 -> ... -> 200
        for (k = 209; k >= 200; k--)
            add_word(OP_EDGE, vertex_t'(k), vertex_t'(k + 1));
        add_word(OP_EDGE, 8'd210, 8'd200);         // walks and compresses the chain
        add_word(OP_EDGE, 8'd210, 8'd3);           // joins the chain tree under root 3
        add_word(OP_CLEAR, 8'h00, 8'h00);
        add_word(OP_EDGE, 8'd170, 8'd85);          // alternating bit patterns

        total = edge_words.size() + RANDOM_WORDS;
        while (edge_words.size() < total)
        begin
            if (!big_done && edge_words.size() > 350)
            begin
                big_done = 1'b1;
                add_word(OP_CLEAR, vertex_t'($urandom), vertex_t'($urandom));
                repeat (200)
                    add_word(OP_EDGE, vertex_t'($urandom), vertex_t'($urandom));
            end
            else if ($urandom_range(0, 9) >= 8)
            begin
                // Noise: anywhere in the range, the odd stray clear
                repeat ($urandom_range(3, 12))
                    add_word(($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_EDGE,
                             vertex_t'($urandom), vertex_t'($urandom));
            end
            else
            begin
                base = $urandom_range(0, 255);
                span = $urandom_range(2, 40);
                add_word(OP_CLEAR, vertex_t'($urandom), vertex_t'($urandom));
                if ($urandom_range(0, 2) == 0)
                    for (k = span - 1; k >= 1; k--)
                        add_word(OP_EDGE, vertex_t'(base + k - 1), vertex_t'(base + k));
                repeat ($urandom_range(span / 2 + 1, span * 2))
                    add_word(OP_EDGE, vertex_t'(base + $urandom_range(0, span - 1)),
                             vertex_t'(base + $urandom_range(0, span - 1)));
            end
        end
    endtask

    // Sender: one word held until accepted, with random gaps between some words.
    initial
    begin
        int unsigned i;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_EDGE;
        vertex_a     = '0;
        vertex_b     = '0;
        calm_tail    = 1'b0;
        hold_request = 1'b0;
        build_stimulus();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < edge_words.size(); i++)
        begin
            calm_tail = (i + CALM_WORDS >= edge_words.size());
            if (i == PRESSURE_AT)
                hold_request = 1'b1;
            if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid <= 1'b1;
            op       <= edge_words[i].kind;
            vertex_a <= edge_words[i].a;
            vertex_b <= edge_words[i].b;
            // Word stays put until the block takes it
            forever
            begin
                @(posedge clk);
                if (!in_stall)
                    break;
            end
            sb.note_word(edge_words[i].kind, edge_words[i].a, edge_words[i].b);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then a few spare cycles to catch any stray word
        while (sb.pending_tree_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("kruskal_union_find_edge_filter_core regression: pass");
        else
            $display("kruskal_union_find_edge_filter_core regression: fail");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off so the output register
    // and the sequencer both fill and the block stalls its input.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall   <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result check on every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(taken, tree_edge_a, tree_edge_b, edge_count);
    end

    // Watchdog: ends a hung run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("kruskal_union_find_edge_filter_core regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
